### hdl/f2iq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package f2iq_pkg;

    localparam int unsigned DIV_W      = 24;
    localparam int unsigned REM_W      = DIV_W + 1;
    localparam int unsigned QUO_W      = 55;
    localparam int unsigned DIV_STEPS  = 5;
    localparam int unsigned DIV_STAGES = QUO_W / DIV_STEPS;
    localparam int unsigned EXP_W      = 10;
    localparam int unsigned ADJ_W      = 33;

    // target type register codes
    localparam logic [2:0] TT_S8  = 3'd0;
    localparam logic [2:0] TT_U8  = 3'd1;
    localparam logic [2:0] TT_S16 = 3'd2;
    localparam logic [2:0] TT_U16 = 3'd3;
    localparam logic [2:0] TT_S32 = 3'd4;

    typedef enum logic [1:0] {
        KIND_FINITE = 2'd0,
        KIND_ZERO   = 2'd1,
        KIND_INF    = 2'd2,
        KIND_NAN    = 2'd3
    } f2iq_kind_t;

    typedef struct packed {
        f2iq_kind_t               kind;
        logic                     sign;
        logic signed [EXP_W-1:0]  exp;
        logic [2:0]               ttype;
        logic signed [ADJ_W-1:0]  adj;
        logic [DIV_W-1:0]         divisor;
    } f2iq_side_t;

endpackage

`default_nettype wire

### hdl/f2iq_unpack.sv
`timescale 1ns / 1ps
`default_nettype none

module f2iq_unpack
    import f2iq_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic [31:0]        sample_bits,
    input  wire logic [31:0]        scale_bits,
    input  wire logic [31:0]        channel_offset,
    input  wire logic [2:0]         ttype,
    output logic                    out_valid,
    output logic [REM_W-1:0]        out_rem,
    output f2iq_side_t              out_side
);

    function automatic logic [4:0] lead_zeros(input logic [23:0] m);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 24; i++) begin
            if (m[i]) n = 5'(23 - i);
        end
        return n;
    endfunction

    logic [23:0]             mant_x, mant_k, nm_x, nm_k;
    logic [4:0]              lz_x, lz_k;
    logic signed [EXP_W-1:0] ex, ek;
    logic                    zx, zk, ix, ik, nx, nk;
    f2iq_kind_t              kind;
    logic [31:0]             zp;
    logic signed [ADJ_W-1:0] adj;

    always_comb begin
        mant_x = {|sample_bits[30:23], sample_bits[22:0]};
        mant_k = {|scale_bits[30:23], scale_bits[22:0]};
        lz_x   = lead_zeros(mant_x);
        lz_k   = lead_zeros(mant_k);
        nm_x   = mant_x << lz_x;
        nm_k   = mant_k << lz_k;
        ex = $signed({2'b00, (sample_bits[30:23] == 8'd0) ? 8'd1 : sample_bits[30:23]})
             - 10'sd127 - $signed({5'b00000, lz_x});
        ek = $signed({2'b00, (scale_bits[30:23] == 8'd0) ? 8'd1 : scale_bits[30:23]})
             - 10'sd127 - $signed({5'b00000, lz_k});
        zx = (sample_bits[30:0] == 31'd0);
        zk = (scale_bits[30:0] == 31'd0);
        ix = (sample_bits[30:23] == 8'hff) && (sample_bits[22:0] == 23'd0);
        ik = (scale_bits[30:23] == 8'hff) && (scale_bits[22:0] == 23'd0);
        nx = (sample_bits[30:23] == 8'hff) && (sample_bits[22:0] != 23'd0);
        nk = (scale_bits[30:23] == 8'hff) && (scale_bits[22:0] != 23'd0);
        priority if (nx || nk || (ix && ik) || (zx && zk)) begin
            kind = KIND_NAN;
        end else if (ix || zk) begin
            kind = KIND_INF;
        end else if (zx || ik) begin
            kind = KIND_ZERO;
        end else begin
            kind = KIND_FINITE;
        end
        zp = 32'd0 - channel_offset;
        unique case (ttype)
            TT_S8:   adj = $signed({{25{zp[7]}}, zp[7:0]});
            TT_U8:   adj = $signed({25'd0, zp[7:0]});
            TT_S16:  adj = $signed({{17{zp[15]}}, zp[15:0]});
            TT_U16:  adj = $signed({17'd0, zp[15:0]});
            TT_S32:  adj = $signed(33'd0 - {channel_offset[31], channel_offset});
            default: adj = '0;
        endcase
    end

    logic                    v1_reg;
    logic [23:0]             mx1_reg, mk1_reg;
    logic signed [EXP_W-1:0] ex1_reg, ek1_reg;
    f2iq_kind_t              kind1_reg;
    logic                    sign1_reg;
    logic [2:0]              ttype1_reg;
    logic signed [ADJ_W-1:0] adj1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
        if (en) begin
            mx1_reg    <= nm_x;
            mk1_reg    <= nm_k;
            ex1_reg    <= ex;
            ek1_reg    <= ek;
            kind1_reg  <= kind;
            sign1_reg  <= sample_bits[31] ^ scale_bits[31];
            ttype1_reg <= ttype;
            adj1_reg   <= adj;
        end
    end

    // align dividend so the first quotient bit is one
    logic       ge;
    f2iq_side_t side_next;
    logic [REM_W-1:0] rem_next;

    always_comb begin
        ge                = (mx1_reg >= mk1_reg);
        rem_next          = ge ? {1'b0, mx1_reg} : {mx1_reg, 1'b0};
        side_next.kind    = kind1_reg;
        side_next.sign    = sign1_reg;
        side_next.exp     = ex1_reg - ek1_reg - (ge ? 10'sd0 : 10'sd1);
        side_next.ttype   = ttype1_reg;
        side_next.adj     = adj1_reg;
        side_next.divisor = mk1_reg;
    end

    logic             v2_reg;
    logic [REM_W-1:0] rem2_reg;
    f2iq_side_t       side2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            rem2_reg  <= rem_next;
            side2_reg <= side_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_rem   = rem2_reg;
    assign out_side  = side2_reg;

endmodule

`default_nettype wire

### hdl/f2iq_div_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module f2iq_div_stage
    import f2iq_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic [REM_W-1:0]   in_rem,
    input  wire logic [QUO_W-1:0]   in_quo,
    input  wire f2iq_side_t         in_side,
    output logic                    out_valid,
    output logic [REM_W-1:0]        out_rem,
    output logic [QUO_W-1:0]        out_quo,
    output f2iq_side_t              out_side
);

    logic [REM_W-1:0] rem;
    logic [REM_W:0]   diff;
    logic [QUO_W-1:0] quo;

    // restoring division, one quotient bit per step
    always_comb begin
        rem = in_rem;
        quo = in_quo;
        for (int i = 0; i < DIV_STEPS; i++) begin
            diff = {1'b0, rem} - {2'b00, in_side.divisor};
            if (!diff[REM_W]) begin
                rem = diff[REM_W-1:0];
            end
            quo = {quo[QUO_W-2:0], ~diff[REM_W]};
            rem = {rem[REM_W-2:0], 1'b0};
        end
    end

    logic             valid_reg;
    logic [REM_W-1:0] rem_reg;
    logic [QUO_W-1:0] quo_reg;
    f2iq_side_t       side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            rem_reg  <= rem;
            quo_reg  <= quo;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

### hdl/f2iq_finish.sv
`timescale 1ns / 1ps
`default_nettype none

module f2iq_finish
    import f2iq_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic [REM_W-1:0]   in_rem,
    input  wire logic [QUO_W-1:0]   in_quo,
    input  wire f2iq_side_t         in_side,
    output logic                    out_valid,
    output logic [31:0]             q_level,
    output logic                    clipped
);

    // stage 1: round quotient to float or double precision
    logic             remnz, dbl, carry;
    logic [53:0]      sumd;
    logic [24:0]      sums;
    logic [52:0]      m53;
    logic signed [EXP_W-1:0] exp_r;
    f2iq_kind_t       kind_r;

    always_comb begin
        remnz = (in_rem != '0);
        dbl   = (in_side.ttype == TT_S32);
        sumd  = {1'b0, in_quo[54:2]}
                + 54'(in_quo[1] & (in_quo[0] | remnz | in_quo[2]));
        sums  = {1'b0, in_quo[54:31]}
                + 25'(in_quo[30] & ((|in_quo[29:0]) | remnz | in_quo[31]));
        if (dbl) begin
            carry = sumd[53];
            m53   = carry ? {1'b1, 52'd0} : sumd[52:0];
        end else begin
            carry = sums[24];
            m53   = carry ? {1'b1, 52'd0} : {sums[23:0], 29'd0};
        end
        exp_r  = in_side.exp + (carry ? 10'sd1 : 10'sd0);
        kind_r = in_side.kind;
        if (in_side.kind == KIND_FINITE) begin
            if (exp_r >= 10'sd33) begin
                kind_r = KIND_INF;
            end else if (exp_r < -10'sd1) begin
                kind_r = KIND_ZERO;
            end
        end
    end

    logic                    v1_reg;
    logic [52:0]             m1_reg;
    logic signed [EXP_W-1:0] e1_reg;
    f2iq_kind_t              k1_reg;
    logic                    s1_reg;
    logic [2:0]              t1_reg;
    logic signed [ADJ_W-1:0] a1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
        if (en) begin
            m1_reg <= m53;
            e1_reg <= exp_r;
            k1_reg <= kind_r;
            s1_reg <= in_side.sign;
            t1_reg <= in_side.ttype;
            a1_reg <= in_side.adj;
        end
    end

    // stage 2: align to the binary point
    logic [5:0]   sh;
    logic [105:0] wide;

    always_comb begin
        sh   = 6'(10'sd52 - e1_reg);
        wide = {m1_reg, 53'd0} >> sh;
    end

    logic                    v2_reg;
    logic [32:0]             ip2_reg;
    logic                    g2_reg, st2_reg;
    f2iq_kind_t              k2_reg;
    logic                    s2_reg;
    logic [2:0]              t2_reg;
    logic signed [ADJ_W-1:0] a2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            ip2_reg <= wide[85:53];
            g2_reg  <= wide[52];
            st2_reg <= |wide[51:0];
            k2_reg  <= k1_reg;
            s2_reg  <= s1_reg;
            t2_reg  <= t1_reg;
            a2_reg  <= a1_reg;
        end
    end

    // stage 3: round half to even, apply sign
    logic [33:0]        mag;
    logic signed [34:0] sv;

    always_comb begin
        mag = {1'b0, ip2_reg} + 34'(g2_reg & (st2_reg | ip2_reg[0]));
        if (k2_reg == KIND_ZERO) begin
            mag = '0;
        end
        sv = s2_reg ? $signed(35'd0 - {1'b0, mag}) : $signed({1'b0, mag});
    end

    logic                    v3_reg;
    logic signed [34:0]      sv3_reg;
    f2iq_kind_t              k3_reg;
    logic                    s3_reg;
    logic [2:0]              t3_reg;
    logic signed [ADJ_W-1:0] a3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
        if (en) begin
            sv3_reg <= sv;
            k3_reg  <= k2_reg;
            s3_reg  <= s2_reg;
            t3_reg  <= t2_reg;
            a3_reg  <= a2_reg;
        end
    end

    // stage 4: zero point and saturation
    logic signed [35:0] sum, lo, hi;
    logic               bad_type;
    logic [31:0]        q_next;
    logic               c_next;

    always_comb begin
        sum      = $signed({sv3_reg[34], sv3_reg}) + $signed({{3{a3_reg[32]}}, a3_reg});
        bad_type = 1'b0;
        unique case (t3_reg)
            TT_S8:   begin lo = -36'sd128;        hi = 36'sd127;        end
            TT_U8:   begin lo = 36'sd0;           hi = 36'sd255;        end
            TT_S16:  begin lo = -36'sd32768;      hi = 36'sd32767;      end
            TT_U16:  begin lo = 36'sd0;           hi = 36'sd65535;      end
            TT_S32:  begin lo = -36'sd2147483648; hi = 36'sd2147483647; end
            default: begin lo = 36'sd0;           hi = 36'sd0; bad_type = 1'b1; end
        endcase
        priority if (bad_type || k3_reg == KIND_NAN) begin
            q_next = '0;
            c_next = 1'b1;
        end else if (k3_reg == KIND_INF) begin
            q_next = s3_reg ? lo[31:0] : hi[31:0];
            c_next = 1'b1;
        end else if (sum > hi) begin
            q_next = hi[31:0];
            c_next = 1'b1;
        end else if (sum < lo) begin
            q_next = lo[31:0];
            c_next = 1'b1;
        end else begin
            q_next = sum[31:0];
            c_next = 1'b0;
        end
    end

    logic        v4_reg;
    logic [31:0] q4_reg;
    logic        c4_reg;
    logic [2:0]  t4_reg;
    f2iq_kind_t  k4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
        if (en) begin
            q4_reg <= q_next;
            c4_reg <= c_next;
            t4_reg <= t3_reg;
            k4_reg <= k3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign q_level   = q4_reg;
    assign clipped   = c4_reg;

    a_u8_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && t4_reg == TT_U8) |-> (q4_reg[31:8] == 24'd0))
        else $error("unsigned 8 bit result out of range");

    a_s16_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && t4_reg == TT_S16) |->
        (q4_reg[31:15] == 17'd0 || q4_reg[31:15] == 17'h1ffff))
        else $error("signed 16 bit result out of range");

    a_nan_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && k4_reg == KIND_NAN) |-> (q4_reg == 32'd0 && c4_reg))
        else $error("nan quotient not zero and flagged");

endmodule

`default_nettype wire

### hdl/float_to_int_linear_quantizer_top.sv
// Linear quantizer: each beat carries a single-precision sample, its channel's
// single-precision scale and a signed offset, and yields round_half_even(sample/scale)
// minus the offset, saturated to the type in target_type (s8, u8, s16, u16, s32),
// with a flag for saturation or a NaN quotient. The block takes one beat per
// cycle while the output is not stalled, and registers each result through
// seventeen register stages: two unpack stages, eleven divider stages of five
// quotient bits each, and four rounding and saturation stages. A stall at the
// output holds the whole pipeline.
`timescale 1ns / 1ps
`default_nettype none

module float_to_int_linear_quantizer_top
    import f2iq_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [95:0]  s_tdata,   // sample_bits, scale_bits, channel_offset
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [31:0]       m_tdata,   // quantized level
    output logic              m_tuser,   // clipped
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [2:0] target_type_reg;
    logic       en;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_type_reg <= TT_U8;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            target_type_reg <= pwdata[2:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {29'd0, target_type_reg};

    assign en       = m_tready || !m_tvalid;
    assign s_tready = en;

    logic             dv   [DIV_STAGES+1];
    logic [REM_W-1:0] drem [DIV_STAGES+1];
    logic [QUO_W-1:0] dquo [DIV_STAGES+1];
    f2iq_side_t       dside[DIV_STAGES+1];

    f2iq_unpack u_unpack (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (en),
        .in_valid       (s_tvalid),
        .sample_bits    (s_tdata[31:0]),
        .scale_bits     (s_tdata[63:32]),
        .channel_offset (s_tdata[95:64]),
        .ttype          (target_type_reg),
        .out_valid      (dv[0]),
        .out_rem        (drem[0]),
        .out_side       (dside[0])
    );

    assign dquo[0] = '0;

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        f2iq_div_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (dv[g]),
            .in_rem    (drem[g]),
            .in_quo    (dquo[g]),
            .in_side   (dside[g]),
            .out_valid (dv[g+1]),
            .out_rem   (drem[g+1]),
            .out_quo   (dquo[g+1]),
            .out_side  (dside[g+1])
        );
    end

    f2iq_finish u_finish (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (dv[DIV_STAGES]),
        .in_rem      (drem[DIV_STAGES]),
        .in_quo      (dquo[DIV_STAGES]),
        .in_side     (dside[DIV_STAGES]),
        .out_valid   (m_tvalid),
        .q_level     (m_tdata),
        .clipped     (m_tuser)
    );

endmodule

`default_nettype wire

### tb/sv/f2iq_checker.sv
`timescale 1ns / 1ps

module f2iq_checker
    import f2iq_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [95:0]  s_tdata,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [31:0]  m_tdata,
    input  wire logic         m_tuser,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    input  wire logic         pready,
    output int                fail_count,
    output int                pending,
    output int                result_count
);

    typedef struct packed {
        logic [31:0] level;
        logic        clipped;
    } quant_t;

    localparam real LIMIT_MAG = 1099511627776.0;

    quant_t      quant_q[$];
    logic [2:0]  ttype;

    // single-precision bit pattern widened to a real
    function automatic real widen(input logic [31:0] b);
        logic [63:0] d;
        real         m;
        if (b[30:23] == 8'd0) begin
            m = real'(b[22:0]) * (2.0 ** -149);
            return b[31] ? -m : m;
        end
        d = {b[31], 11'(b[30:23]) + 11'd896, b[22:0], 29'd0};
        return $bitstoreal(d);
    endfunction

    // round a real quotient to single precision, ties to even
    function automatic real narrow(input real v);
        logic [63:0] b;
        logic [34:0] m;
        logic [28:0] lo;
        b = $realtobits(v);
        if (b[62:52] == 11'd0 || b[62:52] == 11'h7ff)
            return v;
        m  = b[63:29];
        lo = b[28:0];
        if (lo > 29'h1000_0000 || (lo == 29'h1000_0000 && m[0]))
            m = m + 35'd1;
        return $bitstoreal({m, 29'd0});
    endfunction

    function automatic longint round_half_even(input real v);
        real    fl;
        real    fr;
        longint r;
        fl = $floor(v);
        fr = v - fl;
        r  = longint'(fl);
        if (fr > 0.5 || (fr == 0.5 && r[0]))
            r = r + 1;
        return r;
    endfunction

    function automatic quant_t quantize(input logic [31:0] xb, input logic [31:0] kb,
                                        input logic [31:0] ob, input logic [2:0] tt);
        quant_t      q;
        longint      lo;
        longint      hi;
        longint      adj;
        longint      res;
        logic [31:0] zp;
        logic        x_nan;
        logic        k_nan;
        logic        x_inf;
        logic        k_inf;
        logic        x_zero;
        logic        k_zero;
        logic        neg;
        real         v;
        zp = 32'd0 - ob;
        case (tt)
            TT_S8: begin
                lo = -128; hi = 127; adj = longint'($signed(zp[7:0]));
            end
            TT_U8: begin
                lo = 0; hi = 255; adj = longint'(zp[7:0]);
            end
            TT_S16: begin
                lo = -32768; hi = 32767; adj = longint'($signed(zp[15:0]));
            end
            TT_U16: begin
                lo = 0; hi = 65535; adj = longint'(zp[15:0]);
            end
            TT_S32: begin
                lo = -64'sd2147483648; hi = 2147483647; adj = -longint'($signed(ob));
            end
            default: begin
                q.level   = '0;
                q.clipped = 1'b1;
                return q;
            end
        endcase
        x_nan  = (xb[30:23] == 8'hff) && (xb[22:0] != 0);
        k_nan  = (kb[30:23] == 8'hff) && (kb[22:0] != 0);
        x_inf  = (xb[30:0] == 31'h7f80_0000);
        k_inf  = (kb[30:0] == 31'h7f80_0000);
        x_zero = (xb[30:0] == 31'd0);
        k_zero = (kb[30:0] == 31'd0);
        neg    = xb[31] ^ kb[31];
        q.clipped = 1'b1;
        if (x_nan || k_nan || (x_zero && k_zero) || (x_inf && k_inf)) begin
            q.level = '0;
            return q;
        end
        if (x_inf || k_zero) begin
            q.level = neg ? lo[31:0] : hi[31:0];
            return q;
        end
        if (x_zero || k_inf)
            v = 0.0;
        else
            v = widen(xb) / widen(kb);
        if (tt != TT_S32)
            v = narrow(v);
        if (v > LIMIT_MAG) begin
            q.level = hi[31:0];
        end else if (v < -LIMIT_MAG) begin
            q.level = lo[31:0];
        end else begin
            res = round_half_even(v) + adj;
            q.clipped = 1'b0;
            if (res > hi) begin
                res = hi; q.clipped = 1'b1;
            end else if (res < lo) begin
                res = lo; q.clipped = 1'b1;
            end
            q.level = res[31:0];
        end
        return q;
    endfunction

    assign pending = quant_q.size();

    always @(posedge aclk) begin
        quant_t got;
        quant_t want;
        if (!aresetn) begin
            ttype        <= TT_U8;
            fail_count   <= 0;
            result_count <= 0;
            quant_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
                ttype <= pwdata[2:0];
            if (s_tvalid && s_tready)
                quant_q.push_back(quantize(s_tdata[31:0], s_tdata[63:32], s_tdata[95:64],
                                           ttype));
            if (m_tvalid && m_tready) begin
                got.level   = m_tdata;
                got.clipped = m_tuser;
                result_count <= result_count + 1;
                if (quant_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result beat: value %h clipped %b",
                                 got.level, got.clipped);
                    fail_count <= fail_count + 1;
                end else begin
                    want = quant_q.pop_front();
                    if (want != got) begin
                        if (fail_count < 10)
                            $display("mismatch: expected %h/%b got %h/%b",
                                     want.level, want.clipped,
                                     got.level, got.clipped);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

### tb/sv/tb_float_to_int_linear_quantizer_top.sv
`timescale 1ns / 1ps

module tb_float_to_int_linear_quantizer_top;
    import f2iq_pkg::*;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;   // sample_bits, scale_bits, channel_offset
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;   // quantized level
    logic         m_tuser;   // clipped
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    int fail_count;
    int pending;
    int result_count;
    int sent;
    bit gaps_on;
    bit stalls_on;

    float_to_int_linear_quantizer_top DUT (.*);

    f2iq_checker u_checker (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
        .m_tdata, .m_tuser, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .fail_count, .pending, .result_count
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= stalls_on ? ($urandom_range(0, 99) >= 23) : 1'b1;
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send(input logic [31:0] x, input logic [31:0] k, input logic [31:0] o);
        if (gaps_on) begin
            while ($urandom_range(0, 99) < 23) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tdata  <= {o, k, x};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (24) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_float(input int e_lo, input int e_hi);
        return {1'($urandom_range(0, 1)), 8'($urandom_range(e_lo, e_hi)), 23'($urandom)};
    endfunction

    task automatic random_items(input int n);
        logic [31:0] x;
        logic [31:0] k;
        logic [31:0] o;
        int          ke;
        int          sel;
        repeat (n) begin
            sel = $urandom_range(0, 99);
            ke  = $urandom_range(60, 190);
            k   = {1'b0, 8'(ke), 23'($urandom)};
            x   = rand_float(ke + 127 - 8 > 0 ? ke - 8 : 0, ke + 40 < 255 ? ke + 34 : 254);
            if (sel < 30)
                o = 32'($signed($urandom_range(0, 600)) - 300);
            else if (sel < 45)
                o = $urandom;
            else
                o = 32'($signed($urandom_range(0, 80000)) - 40000);
            if (sel < 8)
                x = $urandom;
            else if (sel < 12)
                k = $urandom;
            else if (sel < 16)
                x = {x[31:23], 1'b1, 22'($urandom_range(0, 3)) << 20};
            send(x, k, o);
        end
    endtask

    task automatic directed_items();
        send(32'h3F80_0000, 32'h3F80_0000, 32'd0);
        send(32'h4020_0000, 32'h3F80_0000, 32'd0);
        send(32'hC020_0000, 32'h3F80_0000, 32'd0);
        send(32'h3FC0_0000, 32'h3F80_0000, 32'd0);
        send(32'h3F00_0000, 32'h3F80_0000, 32'd0);
        send(32'h437F_0000, 32'h3F80_0000, 32'd0);
        send(32'h4380_0000, 32'h3F80_0000, 32'd0);
        send(32'h42FF_0000, 32'h3F80_0000, 32'hFFFF_FF80);
        send(32'h7FC0_0000, 32'h3F80_0000, 32'd0);
        send(32'h3F80_0000, 32'hFFC0_0001, 32'd0);
        send(32'h0000_0000, 32'h0000_0000, 32'd0);
        send(32'h7F80_0000, 32'h7F80_0000, 32'd0);
        send(32'h3F80_0000, 32'h0000_0000, 32'd0);
        send(32'hBF80_0000, 32'h8000_0000, 32'd0);
        send(32'h7F80_0000, 32'h3F80_0000, 32'd5);
        send(32'hFF80_0000, 32'h3F80_0000, 32'd5);
        send(32'h4040_0000, 32'h7F80_0000, 32'h8000_0000);
        send(32'h7F7F_FFFF, 32'h0000_0001, 32'h7FFF_FFFF);
        send(32'h0000_0001, 32'h7F7F_FFFF, 32'hFFFF_FFFF);
        send(32'h8000_0000, 32'h3F80_0000, 32'h8000_0000);
        send(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(32'h4F00_0000, 32'h3F80_0000, 32'd0);
    endtask

    initial begin
        logic [2:0] plan [8];
        plan = '{TT_U8, TT_S8, TT_S16, TT_U16, TT_S32, 3'd7, TT_S32, TT_S8};
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        sent      = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        directed_items();
        drain();
        foreach (plan[i]) begin
            reg_write(3'd0, {29'd0, plan[i]});
            directed_items();
            if (i == 2) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            random_items(plan[i] == 3'd7 ? 40 : 190);
            gaps_on   = 1'b1;
            stalls_on = 1'b1;
            drain();
        end
        $display("sent %0d sample beats over %0d target type settings, %0d results checked",
                 sent, 9, result_count);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
